// ===== rtl/sqw_pkg.sv =====
// ----------------------------------------------------------------------------
// sqw_pkg: shared types and constants for the square-wave sound channels
// Holds the input modes, register map, channel control and status structs and the
// length-load and duty-pattern tables.
// ----------------------------------------------------------------------------
package sqw_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } sqw_mode_t;

  localparam logic [15:0] FRAME_PERIOD_RESET = 16'd7457;

  localparam logic [4:0] ADDR_CH_ENABLE  = 5'h15;
  localparam logic [4:0] ADDR_FRAME_CTRL = 5'h17;

  localparam logic [1:0] REG_DUTY      = 2'd0;
  localparam logic [1:0] REG_SWEEP     = 2'd1;
  localparam logic [1:0] REG_PERIOD_LO = 2'd2;
  localparam logic [1:0] REG_PERIOD_HI = 2'd3;

  localparam logic [10:0] PERIOD_MIN = 11'd8;

  typedef struct packed {
    logic       tick;       // step the period timer
    logic       quarter;    // level decay step
    logic       half;       // sweep and length step
    logic       wr_en;
    logic [1:0] wr_reg;
    logic [7:0] wr_data;
    logic       len_clear;
    logic       ones_comp;  // sweep negate in ones complement
  } sqw_ctrl_t;

  typedef struct packed {
    logic [3:0] level_out;  // output after this cycle's timer step
    logic       len_nz;
  } sqw_stat_t;

  function automatic logic [7:0] len_load(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;  5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;  5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;  5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;  5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;  5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;  5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;  5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;  5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // One bit per sequencer position, position 0 in bit 0.
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'b0000_0010;
      2'd1:    pat = 8'b0000_0110;
      2'd2:    pat = 8'b0001_1110;
      2'd3:    pat = 8'b1111_1001;
      default: pat = 8'b0000_0000;
    endcase
    return pat[pos];
  endfunction

endpackage

// ===== rtl/square_wave_sound_channels_top.sv =====
// ----------------------------------------------------------------------------
// square_wave_sound_channels_top: two square-wave channels and frame sequencer
// Input transactions are CPU ticks, register writes or status reads; each
// gives one result transaction carrying a sample, a status byte or zeros.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item. in_tuser = mode (tick, write, read),
//           in_tdata = register offset and write byte.
//   out_* : one result per input transaction, in order. out_tuser flags a
//           sample or a status answer; out_tdata carries sample and status.
//   cfg_* : write frame_period (ticks between frame steps) while idle.
// Results: a result is registered on acceptance and shows on out_* once those ahead are taken.
// Throughput: one item per clock while the queue has room. All state updates
//   for an item are done in the cycle of acceptance by one pass of logic
//   through the two channel units and the frame sequencer.
// The results go into a two-entry output queue, so an item is still taken
//   while one finished result waits; in_tready drops only when both entries
//   are full, and comes back on the cycle after the receiver takes one.
// Reset (rst_n low, synchronous) clears all channel and sequencer state,
//   empties the queue and sets frame_period to 7457.
// ----------------------------------------------------------------------------
module square_wave_sound_channels_top
  import sqw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // frame_period
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [4:0] address, [12:5] write_data, zero above
  input  logic [1:0]  in_tuser,      // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [4:0] sample, [12:5] read_data, zero above
  output logic [1:0]  out_tuser      // [0] sample_valid, [1] read_valid
);

  typedef struct packed {
    logic       rd_valid;
    logic       smp_valid;
    logic [7:0] rd_data;
    logic [4:0] sample;
  } result_t;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [15:0] frame_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r <= FRAME_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      frame_period_r <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Decode of the accepted transaction
  // --------------------------------------------------------------------------
  logic       accept;
  logic [4:0] addr;
  logic [7:0] wdata;
  logic       is_tick, is_write, is_read;

  assign accept = in_tvalid && in_tready;
  assign addr   = in_tdata[4:0];
  assign wdata  = in_tdata[12:5];

  always_comb begin
    is_tick  = 1'b0;
    is_write = 1'b0;
    is_read  = 1'b0;
    case (sqw_mode_t'(in_tuser))
      MODE_TICK:  is_tick  = accept;
      MODE_WRITE: is_write = accept;
      MODE_READ:  is_read  = accept;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame sequencer
  // --------------------------------------------------------------------------
  logic        parity_r,  parity_nxt;
  logic [15:0] fdiv_r,    fdiv_nxt;
  logic [2:0]  fstep_r,   fstep_nxt;
  logic        five_r,    five_nxt;
  logic        fflag_r,   fflag_nxt;

  logic        timer_step;
  logic        frame_clk;
  logic [2:0]  step_inc;
  logic        quarter, half;
  logic [15:0] fdiv_inc;

  assign timer_step = is_tick && !parity_r;
  assign frame_clk  = is_tick && (fdiv_r == 16'd0);
  assign step_inc   = fstep_r + 3'd1;
  assign fdiv_inc   = fdiv_r + 16'd1;

  always_comb begin
    quarter = 1'b0;
    half    = 1'b0;
    if (frame_clk) begin
      quarter = (step_inc inside {3'd1, 3'd2, 3'd3, 3'd5});
      half    = (step_inc inside {3'd2, 3'd5});
    end
  end

  always_comb begin
    parity_nxt = parity_r;
    fdiv_nxt   = fdiv_r;
    fstep_nxt  = fstep_r;
    five_nxt   = five_r;
    fflag_nxt  = fflag_r;

    if (is_tick) begin
      parity_nxt = !parity_r;
      // A period of zero compares as one: the divider stays at zero.
      fdiv_nxt   = (fdiv_inc >= frame_period_r) ? 16'd0 : fdiv_inc;
      if (frame_clk) begin
        if ((step_inc == 3'd4 && !five_r) || step_inc >= 3'd5) begin
          fstep_nxt = 3'd0;
        end else begin
          fstep_nxt = step_inc;
        end
      end
    end

    if (is_write && addr == ADDR_FRAME_CTRL) begin
      five_nxt  = wdata[7];
      fflag_nxt = wdata[6];
      fstep_nxt = 3'd0;
    end

    // Drop the frame flag once it has been reported.
    if (is_read) begin
      fflag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
      fdiv_r   <= '0;
      fstep_r  <= '0;
      five_r   <= 1'b0;
      fflag_r  <= 1'b0;
    end else begin
      parity_r <= parity_nxt;
      fdiv_r   <= fdiv_nxt;
      fstep_r  <= fstep_nxt;
      five_r   <= five_nxt;
      fflag_r  <= fflag_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Channels
  // --------------------------------------------------------------------------
  sqw_ctrl_t ch_ctrl [2];
  sqw_stat_t ch_stat [2];

  logic ch_reg_hit;
  logic en_write;

  // Channel registers sit at offsets 0..7, channel chosen by bit 2.
  assign ch_reg_hit = is_write && (addr[4:3] == 2'b00);
  assign en_write   = is_write && (addr == ADDR_CH_ENABLE);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      ch_ctrl[c].tick      = timer_step;
      ch_ctrl[c].quarter   = quarter;
      ch_ctrl[c].half      = half;
      ch_ctrl[c].wr_en     = ch_reg_hit && (addr[2] == c[0]);
      ch_ctrl[c].wr_reg    = addr[1:0];
      ch_ctrl[c].wr_data   = wdata;
      ch_ctrl[c].len_clear = en_write && !wdata[c];
      ch_ctrl[c].ones_comp = (c == 0);
    end
  end

  sqw_pulse u_pulse0 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ch_ctrl[0]),
    .stat  (ch_stat[0])
  );

  sqw_pulse u_pulse1 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ch_ctrl[1]),
    .stat  (ch_stat[1])
  );

  // --------------------------------------------------------------------------
  // Result for the accepted transaction
  // --------------------------------------------------------------------------
  result_t res;

  always_comb begin
    res = '0;
    if (timer_step) begin
      res.smp_valid = 1'b1;
      res.sample    = {1'b0, ch_stat[0].level_out} + {1'b0, ch_stat[1].level_out};
    end
    if (is_read) begin
      res.rd_valid = 1'b1;
      res.rd_data  = {1'b0, fflag_r, 4'b0000, ch_stat[1].len_nz, ch_stat[0].len_nz};
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output queue, head in slot 0
  // --------------------------------------------------------------------------
  result_t    q_r [2];
  result_t    q_nxt [2];
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign in_tready  = (count_r != 2'd2);
  assign out_tvalid = (count_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    q_nxt[0]  = q_r[0];
    q_nxt[1]  = q_r[1];
    count_nxt = count_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (accept) begin
      if (count_r == 2'd0 || (pop && count_r == 2'd1)) begin
        q_nxt[0] = res;
      end else begin
        q_nxt[1] = res;
      end
    end
    case ({accept, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_tdata = {3'b000, q_r[0].rd_data, q_r[0].sample};
  assign out_tuser = {q_r[0].rd_valid, q_r[0].smp_valid};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("result flags both a sample and a status answer");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[4:0] <= 5'd30))
    else $error("sample above the sum of two full levels");

  a_no_stray_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[4:0] == 5'd0))
    else $error("sample bits set on a result without a sample");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted transaction left no result in the queue");

endmodule

// ===== rtl/sqw_pulse.sv =====
// ----------------------------------------------------------------------------
// sqw_pulse: one square-wave channel
// Period timer, duty sequencer, level decay, sweep and length counter.
// ----------------------------------------------------------------------------
module sqw_pulse
  import sqw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sqw_ctrl_t ctrl,
  output sqw_stat_t stat
);

  logic [1:0]  duty_r,     duty_nxt;
  logic        halt_r,     halt_nxt;
  logic        const_r,    const_nxt;
  logic [3:0]  level_r,    level_nxt;
  logic [7:0]  sweep_r,    sweep_nxt;
  logic        reload_r,   reload_nxt;
  logic [2:0]  sdiv_r,     sdiv_nxt;
  logic [10:0] period_r,   period_nxt;
  logic [10:0] pcount_r,   pcount_nxt;
  logic [7:0]  len_r,      len_nxt;
  logic [2:0]  pos_r,      pos_nxt;

  logic [10:0] change;
  logic [10:0] period_hi;

  assign change    = period_r >> sweep_r[2:0];
  assign period_hi = {ctrl.wr_data[2:0], period_r[7:0]};

  always_comb begin
    duty_nxt   = duty_r;
    halt_nxt   = halt_r;
    const_nxt  = const_r;
    level_nxt  = level_r;
    sweep_nxt  = sweep_r;
    reload_nxt = reload_r;
    sdiv_nxt   = sdiv_r;
    period_nxt = period_r;
    pcount_nxt = pcount_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;

    if (ctrl.tick) begin
      if (pcount_r == 11'd0) begin
        pcount_nxt = period_r;
        pos_nxt    = pos_r + 3'd1;
      end else begin
        pcount_nxt = pcount_r - 11'd1;
      end
    end

    if (ctrl.quarter && halt_r && !const_r) begin
      level_nxt = level_r - 4'd1;
    end

    if (ctrl.half) begin
      if (reload_r) begin
        sdiv_nxt   = sweep_r[6:4];
        reload_nxt = 1'b0;
      end else if (sdiv_r != 3'd0) begin
        sdiv_nxt = sdiv_r - 3'd1;
      end else begin
        sdiv_nxt = sweep_r[6:4];
        if (sweep_r[7]) begin
          if (sweep_r[3]) begin
            period_nxt = period_r - change - {10'd0, ctrl.ones_comp};
          end else begin
            period_nxt = period_r + change;
          end
        end
      end
      if (!halt_r && len_r != 8'd0) begin
        len_nxt = len_r - 8'd1;
      end
    end

    if (ctrl.wr_en) begin
      case (ctrl.wr_reg)
        REG_DUTY: begin
          duty_nxt  = ctrl.wr_data[7:6];
          halt_nxt  = ctrl.wr_data[5];
          const_nxt = ctrl.wr_data[4];
          level_nxt = ctrl.wr_data[3:0];
        end
        REG_SWEEP: begin
          sweep_nxt  = ctrl.wr_data;
          reload_nxt = 1'b1;
        end
        REG_PERIOD_LO: begin
          period_nxt = {period_r[10:8], ctrl.wr_data};
        end
        REG_PERIOD_HI: begin
          period_nxt = period_hi;
          pcount_nxt = period_hi;
          pos_nxt    = 3'd0;
          len_nxt    = len_load(ctrl.wr_data[7:3]);
        end
        default: begin
        end
      endcase
    end

    if (ctrl.len_clear) begin
      len_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r   <= '0;
      halt_r   <= 1'b0;
      const_r  <= 1'b0;
      level_r  <= '0;
      sweep_r  <= '0;
      reload_r <= 1'b0;
      sdiv_r   <= '0;
      period_r <= '0;
      pcount_r <= '0;
      len_r    <= '0;
      pos_r    <= '0;
    end else begin
      duty_r   <= duty_nxt;
      halt_r   <= halt_nxt;
      const_r  <= const_nxt;
      level_r  <= level_nxt;
      sweep_r  <= sweep_nxt;
      reload_r <= reload_nxt;
      sdiv_r   <= sdiv_nxt;
      period_r <= period_nxt;
      pcount_r <= pcount_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // Sample uses the stepped duty position and the pre-frame-step state.
  always_comb begin
    stat.len_nz = (len_r != 8'd0);
    if (duty_bit(duty_r, pos_nxt) && period_r >= PERIOD_MIN && len_r != 8'd0) begin
      stat.level_out = level_r;
    end else begin
      stat.level_out = 4'd0;
    end
  end

endmodule
